// ===== src/uart_command_frame_parser_defines.svh =====
// Assertion macros for the UART command frame parser.
// Used by modules that check their own control logic; needs clk and rst_n in scope.
`ifndef UART_COMMAND_FRAME_PARSER_DEFINES_SVH
`define UART_COMMAND_FRAME_PARSER_DEFINES_SVH

// Check that cons holds in the same cycle as ant
`define UCFP_ASSERT_SAME(label, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ant
`define UCFP_ASSERT_NEXT(label, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ucfp_pkg.sv =====
// Shared types and constants for the UART command frame parser.
// No dependencies; imported by every module of the block.
package ucfp_pkg;

    localparam logic [7:0] JAM_BYTE      = 8'd0;
    localparam logic [7:0] TYPE_LIMIT    = 8'd6;
    localparam logic [7:0] MIN_FRAME_LEN = 8'd2;
    localparam logic [7:0] PTR_FRAME_LEN = 8'd11;
    localparam logic [2:0] TYPE_CHAR     = 3'd1;
    localparam logic [2:0] TYPE_PTR      = 3'd3;

    localparam logic [7:0] POS_TAG       = 8'd3;
    localparam logic [7:0] POS_ADDR_LO   = 8'd4;
    localparam logic [7:0] POS_ADDR_HI   = 8'd7;
    localparam logic [7:0] POS_LEN_LO    = 8'd8;
    localparam logic [7:0] POS_LEN_HI    = 8'd11;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_JAM     = 3'd1,
        EV_INVALID = 3'd2,
        EV_DONE    = 3'd3,
        EV_LENERR  = 3'd4
    } ev_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_BODY
    } state_t;

    typedef struct packed {
        ev_t         event_res;
        logic [2:0]  frame_type;
        logic        char_valid;
        logic [7:0]  char_out;
        logic [7:0]  cmd_tag;
        logic [31:0] cmd_address;
        logic [31:0] cmd_length;
    } res_t;

endpackage

// ===== src/uart_command_frame_parser.sv =====
// Top level of the UART command frame parser.
// Depends on ucfp_pkg, ucfp_in_stage, ucfp_core and ucfp_out_stage.
//
// Takes one received byte per request and returns exactly one result per
// byte: an event code, the open frame type, a streamed character payload
// byte and, on a good 11-byte pointer frame, its tag, address and length.
// One byte is accepted every clock cycle while the result side is not stalling;
// each byte passes the input register, then the result register, and the
// frame state is updated in the single step between them. Backpressure on
// the result side stalls the input after the input register fills.
module uart_command_frame_parser
    import ucfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] char_out, [15:8] cmd_tag,
                                   // [47:16] cmd_address, [79:48] cmd_length
    output logic [6:0]  m_tuser    // [2:0] event_res, [5:3] frame_type, [6] char_valid
);

    logic       advance;
    logic       in_valid;
    logic [7:0] in_byte;
    res_t       res;

    ucfp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    ucfp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_byte (in_byte),
        .res     (res)
    );

    ucfp_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .res      (res),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== src/ucfp_in_stage.sv =====
// Input register of the UART command frame parser.
// Depends on ucfp_pkg; holds one received byte until the core consumes it.
module ucfp_in_stage
    import ucfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       accept;

    assign s_tready   = !valid_reg || advance;
    assign accept     = s_tvalid && s_tready;
    assign valid_next = accept ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

// ===== src/ucfp_core.sv =====
// Frame state machine and result logic of the UART command frame parser.
// Depends on ucfp_pkg and uart_command_frame_parser_defines.svh.
`include "uart_command_frame_parser_defines.svh"

module ucfp_core
    import ucfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] in_byte,
    output res_t       res
);

    state_t      state_reg;
    state_t      state_next;
    logic [2:0]  type_reg;
    logic [2:0]  type_next;
    logic [7:0]  len_reg;
    logic [7:0]  len_next;
    logic [7:0]  count_reg;
    logic [7:0]  count_next;
    logic [7:0]  tag_reg;
    logic [7:0]  tag_next;
    logic [31:0] addr_reg;
    logic [31:0] addr_next;
    logic [31:0] plen_reg;
    logic [31:0] plen_next;

    logic [7:0]  count_inc;
    logic [7:0]  eff_len;
    logic        short_len;
    logic        complete;

    assign count_inc = count_reg + 8'd1;
    assign eff_len   = (state_reg == ST_LEN) ? in_byte : len_reg;
    assign short_len = (state_reg == ST_LEN) && (in_byte < MIN_FRAME_LEN);
    assign complete  = ((state_reg == ST_LEN) || (state_reg == ST_BODY))
                       && !short_len && (count_inc == eff_len);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_byte != JAM_BYTE && in_byte < TYPE_LIMIT)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (short_len || complete)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_BODY;
                end
            end
            ST_BODY:
            begin
                if (complete)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        type_next  = type_reg;
        len_next   = len_reg;
        count_next = count_reg;
        tag_next   = tag_reg;
        addr_next  = addr_reg;
        plen_next  = plen_reg;
        res        = '0;
        res.event_res = EV_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_byte == JAM_BYTE)
                begin
                    res.event_res = EV_JAM;
                end
                else if (in_byte < TYPE_LIMIT)
                begin
                    type_next      = in_byte[2:0];
                    len_next       = '0;
                    count_next     = 8'd1;
                    tag_next       = '0;
                    addr_next      = '0;
                    plen_next      = '0;
                    res.frame_type = in_byte[2:0];
                end
                else
                begin
                    res.event_res = EV_INVALID;
                end
            end
            ST_LEN:
            begin
                res.frame_type = type_reg;
                count_next     = count_inc;
                if (short_len)
                begin
                    res.event_res = EV_LENERR;
                end
                else
                begin
                    len_next = in_byte;
                end
            end
            ST_BODY:
            begin
                res.frame_type = type_reg;
                count_next     = count_inc;
                if (type_reg == TYPE_CHAR)
                begin
                    res.char_valid = 1'b1;
                    res.char_out   = in_byte;
                end
                else if (type_reg == TYPE_PTR)
                begin
                    if (count_inc == POS_TAG)
                    begin
                        tag_next = in_byte;
                    end
                    else if (count_inc inside {[POS_ADDR_LO:POS_ADDR_HI]})
                    begin
                        addr_next[8*count_inc[1:0] +: 8] = in_byte;
                    end
                    else if (count_inc inside {[POS_LEN_LO:POS_LEN_HI]})
                    begin
                        plen_next[8*count_inc[1:0] +: 8] = in_byte;
                    end
                end
            end
            default:
            begin
                res.event_res = EV_NONE;
            end
        endcase

        if (complete)
        begin
            if (type_reg == TYPE_PTR)
            begin
                if (eff_len == PTR_FRAME_LEN)
                begin
                    res.event_res   = EV_DONE;
                    res.cmd_tag     = tag_next;
                    res.cmd_address = addr_next;
                    res.cmd_length  = plen_next;
                end
                else
                begin
                    res.event_res = EV_LENERR;
                end
            end
            else
            begin
                res.event_res = EV_DONE;
            end
        end

        if (short_len || complete)
        begin
            len_next   = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            type_reg  <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            tag_reg   <= '0;
            addr_reg  <= '0;
            plen_reg  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            tag_reg   <= tag_next;
            addr_reg  <= addr_next;
            plen_reg  <= plen_next;
        end
    end

    `UCFP_ASSERT_SAME(a_body_count_below_len, state_reg == ST_BODY, count_reg < len_reg, "byte count passed declared length")
    `UCFP_ASSERT_SAME(a_cmd_only_on_done, res.event_res != EV_DONE, (res.cmd_tag == '0) && (res.cmd_address == '0) && (res.cmd_length == '0), "pointer fields without completion")
    `UCFP_ASSERT_NEXT(a_event_goes_idle, advance && (res.event_res != EV_NONE), (state_reg == ST_IDLE) && (count_reg == '0), "event did not return to idle")
    `UCFP_ASSERT_SAME(a_char_only_char_frame, res.char_valid, (type_reg == TYPE_CHAR) && (state_reg == ST_BODY), "character byte outside character frame")

endmodule

// ===== src/ucfp_out_stage.sv =====
// Result register of the UART command frame parser.
// Depends on ucfp_pkg; holds one result until the downstream side takes it.
module ucfp_out_stage
    import ucfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  res_t        res,
    output logic        advance,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,
    output logic [6:0]  m_tuser
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign advance    = in_valid && (!valid_reg || m_tready);
    assign valid_next = advance ? 1'b1 : ((valid_reg && m_tready) ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.cmd_length, res_reg.cmd_address, res_reg.cmd_tag,
                       res_reg.char_out};
    assign m_tuser  = {res_reg.char_valid, res_reg.frame_type, res_reg.event_res};

endmodule

// ===== sim/tb_uart_command_frame_parser.sv =====
// Testbench for uart_command_frame_parser: directed byte table, then random command frames.
// Results are checked field by field against a byte-level frame predictor, under random stalls.
// Depends on ucfp_pkg and the RTL of uart_command_frame_parser.
module tb_uart_command_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import ucfp_pkg::*;

    localparam int TARGET_BYTES     = 1400;
    localparam int CALM_AFTER       = 1250;
    localparam int PAUSE_AT         = 700;
    localparam int HOLD_AT_RESULT   = 400;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES     = 10;

    typedef struct packed {
        logic [7:0] rx;
        logic       pinned;
        ev_t        ev;
        logic [2:0] ftype;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [6:0]  m_tuser;

    // frame state of the predictor
    logic        fr_open;
    logic [2:0]  fr_type;
    logic [7:0]  fr_declared;
    logic [7:0]  fr_count;
    logic [7:0]  fr_tag;
    logic [31:0] fr_addr;
    logic [31:0] fr_len;

    res_t pending_results[$];
    int   mismatch_count = 0;
    int   results_seen = 0;
    int   bytes_sent = 0;
    bit   calm = 1'b0;
    bit   long_hold_done = 1'b0;

    stim_row_t directed_rows [27] = '{
        {8'h00, 1'b1, EV_JAM,     3'd0},
        {8'hFF, 1'b1, EV_INVALID, 3'd0},
        {8'h06, 1'b1, EV_INVALID, 3'd0},
        {8'h05, 1'b1, EV_NONE,    3'd5},
        {8'h00, 1'b1, EV_LENERR,  3'd5},
        {8'h01, 1'b1, EV_NONE,    TYPE_CHAR},
        {8'h01, 1'b1, EV_LENERR,  TYPE_CHAR},
        {8'h02, 1'b1, EV_NONE,    3'd2},
        {8'h02, 1'b1, EV_DONE,    3'd2},
        {8'h01, 1'b1, EV_NONE,    TYPE_CHAR},
        {8'h04, 1'b1, EV_NONE,    TYPE_CHAR},
        {8'h00, 1'b0, EV_NONE,    3'd0},
        {8'hFF, 1'b0, EV_NONE,    3'd0},
        {8'h03, 1'b1, EV_NONE,    TYPE_PTR},
        {8'h0B, 1'b1, EV_NONE,    TYPE_PTR},
        {8'hA5, 1'b0, EV_NONE,    3'd0},
        {8'hFF, 1'b0, EV_NONE,    3'd0},
        {8'h00, 1'b0, EV_NONE,    3'd0},
        {8'h80, 1'b0, EV_NONE,    3'd0},
        {8'h01, 1'b0, EV_NONE,    3'd0},
        {8'h00, 1'b0, EV_NONE,    3'd0},
        {8'hFF, 1'b0, EV_NONE,    3'd0},
        {8'h7F, 1'b0, EV_NONE,    3'd0},
        {8'hFE, 1'b0, EV_NONE,    3'd0},
        {8'h03, 1'b1, EV_NONE,    TYPE_PTR},
        {8'h03, 1'b1, EV_NONE,    TYPE_PTR},
        {8'h77, 1'b1, EV_LENERR,  TYPE_PTR}
    };

    uart_command_frame_parser uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic res_t parse_byte(input logic [7:0] b);
        res_t r;
        r = '0;
        if (!fr_open)
        begin
            if (b == JAM_BYTE)
                r.event_res = EV_JAM;
            else if (b < TYPE_LIMIT)
            begin
                fr_open     = 1'b1;
                fr_type     = b[2:0];
                fr_declared = 8'd0;
                fr_count    = 8'd1;
                fr_tag      = 8'd0;
                fr_addr     = 32'd0;
                fr_len      = 32'd0;
                r.frame_type = b[2:0];
            end
            else
                r.event_res = EV_INVALID;
            return r;
        end
        r.frame_type = fr_type;
        fr_count = fr_count + 8'd1;
        if (fr_declared == 8'd0)
        begin
            if (b < MIN_FRAME_LEN)
            begin
                r.event_res = EV_LENERR;
                fr_open     = 1'b0;
                fr_count    = 8'd0;
                return r;
            end
            fr_declared = b;
        end
        else if (fr_type == TYPE_CHAR)
        begin
            r.char_valid = 1'b1;
            r.char_out   = b;
        end
        else if (fr_type == TYPE_PTR)
        begin
            if (fr_count == POS_TAG)
                fr_tag = b;
            else if (fr_count >= POS_ADDR_LO && fr_count <= POS_ADDR_HI)
                fr_addr[8 * (fr_count - POS_ADDR_LO) +: 8] = b;
            else if (fr_count >= POS_LEN_LO && fr_count <= POS_LEN_HI)
                fr_len[8 * (fr_count - POS_LEN_LO) +: 8] = b;
        end
        if (fr_count == fr_declared)
        begin
            if (fr_type == TYPE_PTR && fr_declared != PTR_FRAME_LEN)
                r.event_res = EV_LENERR;
            else
            begin
                r.event_res = EV_DONE;
                if (fr_type == TYPE_PTR)
                begin
                    r.cmd_tag     = fr_tag;
                    r.cmd_address = fr_addr;
                    r.cmd_length  = fr_len;
                end
            end
            fr_open     = 1'b0;
            fr_declared = 8'd0;
            fr_count    = 8'd0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("[%0t] result %0d: %s got %0h expected %0h", $realtime, results_seen,
                 field, got, want);
    endtask

    task automatic queue_expected(input res_t r);
        pending_results = {pending_results, r};
    endtask

    // offer one byte and hold until accepted
    task automatic send_byte(input logic [7:0] b, output res_t predicted);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = parse_byte(b);
        bytes_sent++;
    endtask

    // now and then, until calm, drop the request line for a random burst
    task automatic idle_maybe();
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic send_checked(input logic [7:0] b);
        res_t predicted;
        send_byte(b, predicted);
        queue_expected(predicted);
        idle_maybe();
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] flen);
        send_checked(ftype);
        send_checked(flen);
        for (int i = 2; i < flen; i++)
            send_checked(8'($urandom_range(0, 255)));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls, one long hold-off to back up the input
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!long_hold_done && results_seen >= HOLD_AT_RESULT)
            begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.event_res   = ev_t'(m_tuser[2:0]);
            got.frame_type  = m_tuser[5:3];
            got.char_valid  = m_tuser[6];
            got.char_out    = m_tdata[7:0];
            got.cmd_tag     = m_tdata[15:8];
            got.cmd_address = m_tdata[47:16];
            got.cmd_length  = m_tdata[79:48];
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, event_res", got.event_res, 0);
            else
            begin
                want = pending_results.pop_front();
                if (got.event_res !== want.event_res)
                    report_mismatch("event_res", got.event_res, want.event_res);
                if (got.frame_type !== want.frame_type)
                    report_mismatch("frame_type", got.frame_type, want.frame_type);
                if (got.char_valid !== want.char_valid)
                    report_mismatch("char_valid", got.char_valid, want.char_valid);
                if (got.char_out !== want.char_out)
                    report_mismatch("char_out", got.char_out, want.char_out);
                if (got.cmd_tag !== want.cmd_tag)
                    report_mismatch("cmd_tag", got.cmd_tag, want.cmd_tag);
                if (got.cmd_address !== want.cmd_address)
                    report_mismatch("cmd_address", got.cmd_address, want.cmd_address);
                if (got.cmd_length !== want.cmd_length)
                    report_mismatch("cmd_length", got.cmd_length, want.cmd_length);
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        res_t predicted;
        res_t typed;
        int   pick;
        logic [7:0] ftype;
        logic [7:0] flen;
        bit   paused = 1'b0;

        fr_open     = 1'b0;
        fr_type     = 3'd0;
        fr_declared = 8'd0;
        fr_count    = 8'd0;
        fr_tag      = 8'd0;
        fr_addr     = 32'd0;
        fr_len      = 32'd0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].rx, predicted);
            if (directed_rows[i].pinned)
            begin
                typed = '0;
                typed.event_res  = directed_rows[i].ev;
                typed.frame_type = directed_rows[i].ftype;
                queue_expected(typed);
            end
            else
                queue_expected(predicted);
            idle_maybe();
        end
        drain_results();

        while (bytes_sent < TARGET_BYTES)
        begin
            if (bytes_sent >= CALM_AFTER)
                calm = 1'b1;
            if (!paused && bytes_sent >= PAUSE_AT)
            begin
                paused = 1'b1;
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_checked(8'($urandom_range(0, 255)));
            else if (pick < 14)
            begin
                send_checked(8'($urandom_range(1, 5)));
                send_checked(8'($urandom_range(0, 1)));
            end
            else
            begin
                ftype = 8'($urandom_range(1, 5));
                if (ftype == TYPE_PTR)
                    flen = ($urandom_range(0, 99) < 80) ? PTR_FRAME_LEN
                                                        : 8'($urandom_range(2, 20));
                else if ($urandom_range(0, 99) < 3)
                    flen = 8'($urandom_range(17, 255));
                else
                    flen = 8'($urandom_range(2, 16));
                send_frame(ftype, flen);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
